@@ src/posted_write_buffer_fifo_defines.svh @@
// ----------------------------------------------------------------------------
// posted_write_buffer_fifo_defines
// Assertion macros for the posted write buffer.
// ----------------------------------------------------------------------------
`ifndef POSTED_WRITE_BUFFER_FIFO_DEFINES_SVH
`define POSTED_WRITE_BUFFER_FIFO_DEFINES_SVH

`ifndef ASSERT_OFF
`define PWBF_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("pwbf assertion failed");
`define PWBF_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("pwbf assertion failed");
`else
`define PWBF_ASSERT_IMP(label, clk, rst_n, a, b)
`define PWBF_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

@@ src/pwbf_pkg.sv @@
// ----------------------------------------------------------------------------
// pwbf_pkg
// Shared types, codes and helpers of the posted write buffer.
// ----------------------------------------------------------------------------
package pwbf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_STEP  = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	localparam logic [1:0] KIND_ADDR = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_HALF = 2'd2;
	localparam logic [1:0] KIND_WORD = 2'd3;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_STEP,
		OP_FLUSH,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  kind;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] data;
		logic [3:0]  be;
		logic        seq;
		logic        last;
	} res_t;

	function automatic logic [3:0] lane_mask(logic [1:0] kind, logic [1:0] lo);
		logic [3:0] m;
		case (kind)
			KIND_BYTE: m = 4'b0001 << lo;
			KIND_HALF: m = 4'b0011 << {lo[1], 1'b0};
			KIND_WORD: m = 4'b1111;
			default:   m = 4'b0000;
		endcase
		return m;
	endfunction

	function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

endpackage

@@ src/pwbf_front.sv @@
// ----------------------------------------------------------------------------
// pwbf_front
// Accepts input words, decodes the command and queues them for the engine.
// ----------------------------------------------------------------------------
module pwbf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          command,
	input  logic [1:0]          entry_kind,
	input  logic [31:0]         entry_value,
	output logic                cmd_valid,
	output pwbf_pkg::cmd_t      cmd,
	input  logic                cmd_take
);

	pwbf_pkg::cmd_t slot_q [2];
	logic           rd_q;
	logic           wr_q;
	logic [1:0]     cnt_q;
	pwbf_pkg::cmd_t dec;
	logic           wr_en;
	logic           rd_en;

	always_comb begin
		dec.kind  = entry_kind;
		dec.value = entry_value;
		case (command)
			pwbf_pkg::CMD_PUSH:  dec.op = pwbf_pkg::OP_PUSH;
			pwbf_pkg::CMD_STEP:  dec.op = pwbf_pkg::OP_STEP;
			pwbf_pkg::CMD_FLUSH: dec.op = pwbf_pkg::OP_FLUSH;
			default:             dec.op = pwbf_pkg::OP_NONE;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= !wr_q;
			end
			if (rd_en) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

@@ src/pwbf_back.sv @@
// ----------------------------------------------------------------------------
// pwbf_back
// Write buffer engine: entry queue, held data and drain steps.
// ----------------------------------------------------------------------------
`include "posted_write_buffer_fifo_defines.svh"

module pwbf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  pwbf_pkg::cmd_t cmd,
	output logic           cmd_take,
	input  logic           res_ready,
	output logic           res_valid,
	output pwbf_pkg::res_t res
);

	logic [31:0]                 val_mem [pwbf_pkg::QUEUE_DEPTH];
	logic [1:0]                  kind_mem [pwbf_pkg::QUEUE_DEPTH];
	logic [pwbf_pkg::IDX_W-1:0]  rd_q;
	logic [pwbf_pkg::IDX_W-1:0]  wr_q;
	logic [pwbf_pkg::OCC_W-1:0]  occ_q;
	logic [pwbf_pkg::OCC_W-1:0]  data_q;
	logic [31:0]                 addr_q;
	logic [31:0]                 hval_q;
	logic [1:0]                  hkind_q;
	logic                        held_q;
	logic                        burst_q;
	logic [1:0]                  head_kind_q;
	logic [31:0]                 head_val_q;

	logic        go;
	logic        busy;
	logic        step;
	logic        push_en;
	logic        pop;
	logic        issue;
	logic        push_data;
	logic        pop_data;
	logic [pwbf_pkg::IDX_W-1:0] rd_nxt;

	assign busy      = (occ_q != '0) || held_q;
	assign go        = cmd_valid && res_ready;

	always_comb begin
		step     = 1'b0;
		push_en  = 1'b0;
		cmd_take = 1'b0;
		if (go) begin
			case (cmd.op)
				pwbf_pkg::OP_PUSH: begin
					step     = (occ_q == pwbf_pkg::OCC_W'(pwbf_pkg::QUEUE_DEPTH));
					push_en  = 1'b1;
					cmd_take = 1'b1;
				end
				pwbf_pkg::OP_STEP: begin
					step     = 1'b1;
					cmd_take = 1'b1;
				end
				pwbf_pkg::OP_FLUSH: begin
					step     = busy;
					cmd_take = !busy;
				end
				default: begin
					cmd_take = 1'b1;
				end
			endcase
		end
	end

	assign pop       = step && (occ_q != '0);
	assign issue     = step && held_q;
	assign push_data = push_en && (cmd.kind != pwbf_pkg::KIND_ADDR);
	assign pop_data  = pop && (head_kind_q != pwbf_pkg::KIND_ADDR);
	assign rd_nxt    = pop ? pwbf_pkg::next_idx(rd_q) : rd_q;

	// data entries still queued == writes left after this one
	assign res_valid = issue;
	assign res.addr  = addr_q;
	assign res.data  = hval_q;
	assign res.be    = pwbf_pkg::lane_mask(hkind_q, addr_q[1:0]);
	assign res.seq   = burst_q && (addr_q[9:0] != 10'd0);
	assign res.last  = (cmd.op != pwbf_pkg::OP_FLUSH) || (data_q == '0);

	// head entry is prefetched; a push into the next head slot bypasses
	always_ff @(posedge clk) begin
		if (push_en) begin
			val_mem[wr_q]  <= cmd.value;
			kind_mem[wr_q] <= cmd.kind;
		end
		if (push_en && (wr_q == rd_nxt)) begin
			head_val_q  <= cmd.value;
			head_kind_q <= cmd.kind;
		end else begin
			head_val_q  <= val_mem[rd_nxt];
			head_kind_q <= kind_mem[rd_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			occ_q   <= '0;
			data_q  <= '0;
			addr_q  <= '0;
			hval_q  <= '0;
			hkind_q <= pwbf_pkg::KIND_ADDR;
			held_q  <= 1'b0;
			burst_q <= 1'b0;
		end else begin
			if (issue) begin
				addr_q  <= addr_q + 32'd4;
				burst_q <= 1'b1;
				held_q  <= 1'b0;
			end
			if (pop) begin
				if (head_kind_q == pwbf_pkg::KIND_ADDR) begin
					addr_q  <= head_val_q;
					burst_q <= 1'b0;
					held_q  <= 1'b0;
				end else begin
					hval_q  <= head_val_q;
					hkind_q <= head_kind_q;
					held_q  <= 1'b1;
				end
				rd_q <= pwbf_pkg::next_idx(rd_q);
			end
			if (push_en) begin
				wr_q <= pwbf_pkg::next_idx(wr_q);
			end
			occ_q  <= occ_q + pwbf_pkg::OCC_W'(push_en) - pwbf_pkg::OCC_W'(pop);
			data_q <= data_q + pwbf_pkg::OCC_W'(push_data) - pwbf_pkg::OCC_W'(pop_data);
		end
	end

	`PWBF_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ_q <= pwbf_pkg::OCC_W'(pwbf_pkg::QUEUE_DEPTH))
	`PWBF_ASSERT_IMP(a_data_le_occ, clk, arst_n, 1'b1, data_q <= occ_q)
	`PWBF_ASSERT_IMP(a_res_room, clk, arst_n, res_valid, res_ready && cmd_valid)
	`PWBF_ASSERT_NXT(a_issue_burst, clk, arst_n, issue && !pop, burst_q && !held_q)

endmodule

@@ src/pwbf_rq.sv @@
// ----------------------------------------------------------------------------
// pwbf_rq
// Two-entry result queue between the engine and the bus write port.
// ----------------------------------------------------------------------------
module pwbf_rq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_valid,
	input  pwbf_pkg::res_t res,
	output logic           res_ready,
	output logic           empty,
	input  logic           pop,
	output pwbf_pkg::res_t head
);

	pwbf_pkg::res_t slot_q [2];
	logic           rd_q;
	logic           wr_q;
	logic [1:0]     cnt_q;
	logic           wr_en;
	logic           rd_en;

	assign res_ready = (cnt_q != 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign head      = slot_q[rd_q];
	assign wr_en     = res_valid && res_ready;
	assign rd_en     = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= !wr_q;
			end
			if (rd_en) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

@@ src/posted_write_buffer_fifo.sv @@
// Throughput: one push or step command per cycle while the result queue has room.
// A flush holds the engine, stepping through the queued entries, until none are queued and no data is held.
// The engine stalls when the two-entry result queue is full; the command queue holds two.
// Reset: arst_n asynchronous, active low; clears all control state, no clearing pass.
// ----------------------------------------------------------------------------
// posted_write_buffer_fifo
// Posted write buffer: queues address and data entries, drains them as bus writes.
// ----------------------------------------------------------------------------
module posted_write_buffer_fifo (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [1:0]  entry_kind,
	input  logic [31:0] entry_value,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] bus_address,
	output logic [31:0] bus_data,
	output logic [3:0]  byte_enable,
	output logic        sequential,
	output logic        last
);

	logic           cmd_valid;
	pwbf_pkg::cmd_t cmd;
	logic           cmd_take;
	logic           res_valid;
	logic           res_ready;
	pwbf_pkg::res_t res;
	pwbf_pkg::res_t head;

	pwbf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.entry_kind  (entry_kind),
		.entry_value (entry_value),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take)
	);

	pwbf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	pwbf_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign bus_address = head.addr;
	assign bus_data    = head.data;
	assign byte_enable = head.be;
	assign sequential  = head.seq;
	assign last        = head.last;

endmodule
